>>> hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GNB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GNB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/gnb_pkg.sv
// types, codes and helpers for the gaussian naive bayes classifier
// no dependencies
package gnb_pkg;

   localparam int CLASS_W   = 3;
   localparam int CLASS_CAP = 8;
   localparam int ACC_W     = 40;

   localparam logic [1:0] CMD_BIAS    = 2'd0;
   localparam logic [1:0] CMD_MEAN    = 2'd1;
   localparam logic [1:0] CMD_INV_STD = 2'd2;
   localparam logic [1:0] CMD_FEATURE = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         class_sel;
      logic [5:0]         feature_sel;
      logic signed [31:0] value;
      logic               last_feature;
   } req_type;

   typedef struct packed {
      logic [2:0]         best_class;
      logic signed [39:0] best_score;
   } rsp_type;

   typedef struct packed {
      logic               load;
      logic               write_model;
      logic               acc_issue;
      logic               dec_issue;
      logic               dec_first;
      logic               emit;
      logic               clear_acc;
      logic [CLASS_W-1:0] cls_idx;
   } ctl_type;

   typedef struct packed {
      logic pipe_busy;
   } stat_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
      logic signed [ACC_W-1:0] r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/gnb_ram.sv
// generic simple dual-port ram, registered read
// no dependencies
module gnb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/gnb_controller.sv
// sequencer for model writes, class sweeps and the decision
// depends on gnb_pkg
module gnb_controller
   import gnb_pkg::*;
#(
   parameter int NUM_CLASSES  = 8,
   parameter int NUM_FEATURES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  req_type    req_payload,
   input  logic [3:0] classes_in_use,
   input  stat_type   stat,
   output ctl_type    ctl,
   output logic       busy
);

   localparam int CLS_N = (NUM_CLASSES < CLASS_CAP) ? NUM_CLASSES : CLASS_CAP;
   localparam logic [CLASS_W-1:0] CLS_LAST = CLASS_W'(CLS_N - 1);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_WRITE     = 3'd1;
   localparam logic [2:0] S_ACCUM     = 3'd2;
   localparam logic [2:0] S_DRAIN     = 3'd3;
   localparam logic [2:0] S_DECIDE    = 3'd4;
   localparam logic [2:0] S_DEC_DRAIN = 3'd5;
   localparam logic [2:0] S_EMIT      = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [CLASS_W-1:0] cnt_ff, cnt_in;
   logic               last_ff, last_in;
   logic               feat_ok;
   logic [3:0]         lim;
   logic [CLASS_W-1:0] dec_last;

   assign busy    = (state_ff != S_IDLE);
   assign feat_ok = int'(req_payload.feature_sel) < NUM_FEATURES;

   // classes compared at a decision
   always_comb begin
      priority if (classes_in_use == 4'd0) begin
         lim = 4'd1;
      end else if (int'(classes_in_use) > CLS_N) begin
         lim = 4'(CLS_N);
      end else begin
         lim = classes_in_use;
      end
      dec_last = CLASS_W'(lim - 4'd1);
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      ctl         = '0;
      ctl.cls_idx = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               last_in  = req_payload.last_feature;
               cnt_in   = '0;
               priority if (req_payload.command != CMD_FEATURE) begin
                  state_in = S_WRITE;
               end else if (feat_ok) begin
                  state_in = S_ACCUM;
               end else if (req_payload.last_feature) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WRITE: begin
            ctl.write_model = 1'b1;
            state_in        = S_IDLE;
         end
         S_ACCUM: begin
            ctl.acc_issue = 1'b1;
            if (cnt_ff == CLS_LAST) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = last_ff ? S_DECIDE : S_IDLE;
            end
         end
         S_DECIDE: begin
            ctl.dec_issue = 1'b1;
            ctl.dec_first = (cnt_ff == '0);
            if (cnt_ff == dec_last) begin
               cnt_in   = '0;
               state_in = S_DEC_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DEC_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            ctl.emit      = 1'b1;
            ctl.clear_acc = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule

>>> hw/rtl/gnb_datapath.sv
// model storage, shared z-squared multiply pipeline, accumulators and argmax
// depends on gnb_pkg and gnb_ram
module gnb_datapath
   import gnb_pkg::*;
#(
   parameter int NUM_CLASSES  = 8,
   parameter int NUM_FEATURES = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_payload,
   input  ctl_type  ctl,
   output stat_type stat,
   output rsp_type  rsp_payload
);

   localparam int CLS_N   = (NUM_CLASSES < CLASS_CAP) ? NUM_CLASSES : CLASS_CAP;
   localparam int CLS_AW  = $clog2(CLS_N);
   localparam int FEAT_AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int ADDR_W  = CLS_AW + FEAT_AW;
   localparam int DEPTH   = CLS_N * (2 ** FEAT_AW);

   req_type item_ff;

   logic              cls_ok, feat_ok;
   logic              mean_we, inv_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [15:0]       mean_rd, inv_rd;

   logic [31:0]             bias_ff [CLS_N];
   logic signed [ACC_W-1:0] acc_ff  [CLS_N];

   // multiply pipeline
   logic              v1_ff, v2_ff, v3_ff;
   logic [CLS_AW-1:0] c1_ff, c2_ff, c3_ff;
   logic signed [15:0] x;
   logic signed [16:0] diff_in, inv_s;
   logic signed [33:0] prod_in, p2_ff;
   logic signed [25:0] zf;
   logic signed [15:0] z;
   logic signed [31:0] sq_in;
   logic [30:0]        sq3_ff;
   logic [29:0]        term;

   // accumulator and decision
   logic [CLS_AW-1:0]       rd_idx;
   logic signed [ACC_W-1:0] acc_rd, acc_in, dsum_in;
   logic signed [31:0]      bias_rd;
   logic                    d1_v_ff, d1_first_ff;
   logic [CLASS_W-1:0]      d1_cls_ff;
   logic signed [ACC_W-1:0] d1_score_ff;
   logic signed [ACC_W-1:0] best_score_ff;
   logic [CLASS_W-1:0]      best_cls_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         item_ff <= req_payload;
      end
   end

   assign cls_ok  = int'(item_ff.class_sel) < NUM_CLASSES;
   assign feat_ok = int'(item_ff.feature_sel) < NUM_FEATURES;
   assign mean_we = ctl.write_model && (item_ff.command == CMD_MEAN) && cls_ok && feat_ok;
   assign inv_we  = ctl.write_model && (item_ff.command == CMD_INV_STD) && cls_ok && feat_ok;
   assign wr_addr = {CLS_AW'(item_ff.class_sel), FEAT_AW'(item_ff.feature_sel)};
   assign rd_addr = {CLS_AW'(ctl.cls_idx), FEAT_AW'(item_ff.feature_sel)};

   gnb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_mean_ram (
      .clock   (clock),
      .wr_en   (mean_we),
      .wr_addr (wr_addr),
      .wr_data (item_ff.value[15:0]),
      .rd_addr (rd_addr),
      .rd_data (mean_rd)
   );

   gnb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_inv_ram (
      .clock   (clock),
      .wr_en   (inv_we),
      .wr_addr (wr_addr),
      .wr_data (item_ff.value[15:0]),
      .rd_addr (rd_addr),
      .rd_data (inv_rd)
   );

   always_ff @(posedge clock) begin
      if (ctl.write_model && (item_ff.command == CMD_BIAS) && cls_ok) begin
         bias_ff[CLS_AW'(item_ff.class_sel)] <= item_ff.value;
      end
   end

   // stage 1: diff times inverse std
   assign x       = item_ff.value[15:0];
   assign diff_in = {x[15], x} - {mean_rd[15], mean_rd};
   assign inv_s   = {1'b0, inv_rd};
   assign prod_in = diff_in * inv_s;

   // stage 2: floor to q8.8, saturate, square
   assign zf = p2_ff[33:8];
   always_comb begin
      if (zf[25:15] != {11{zf[25]}}) begin
         z = zf[25] ? 16'sh8000 : 16'sh7fff;
      end else begin
         z = zf[15:0];
      end
   end
   assign sq_in = z * z;
   assign term  = sq3_ff[30:1];

   // stage 3: accumulate
   assign rd_idx  = v3_ff ? c3_ff : CLS_AW'(ctl.cls_idx);
   assign acc_rd  = acc_ff[rd_idx];
   assign bias_rd = bias_ff[rd_idx];
   assign acc_in  = sat_acc({acc_rd[ACC_W-1], acc_rd} - {{(ACC_W-29){1'b0}}, term});
   assign dsum_in = sat_acc({acc_rd[ACC_W-1], acc_rd}
                            + {{(ACC_W-31){bias_rd[31]}}, bias_rd});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         d1_v_ff <= 1'b0;
      end else begin
         v1_ff   <= ctl.acc_issue;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         d1_v_ff <= ctl.dec_issue;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff       <= CLS_AW'(ctl.cls_idx);
      c2_ff       <= c1_ff;
      c3_ff       <= c2_ff;
      p2_ff       <= prod_in;
      sq3_ff      <= sq_in[30:0];
      d1_cls_ff   <= ctl.cls_idx;
      d1_first_ff <= ctl.dec_first;
      d1_score_ff <= dsum_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_acc) begin
         for (int i = 0; i < CLS_N; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (v3_ff) begin
         acc_ff[c3_ff] <= acc_in;
      end
   end

   // running argmax, lowest index wins ties
   always_ff @(posedge clock) begin
      if (d1_v_ff && (d1_first_ff || (d1_score_ff > best_score_ff))) begin
         best_score_ff <= d1_score_ff;
         best_cls_ff   <= d1_cls_ff;
      end
   end

   assign stat.pipe_busy         = v1_ff || v2_ff || v3_ff || d1_v_ff;
   assign rsp_payload.best_class = best_cls_ff;
   assign rsp_payload.best_score = best_score_ff;

endmodule

>>> hw/rtl/gaussian_naive_bayes_classifier.sv
// gaussian naive bayes classifier, top level: csr port, controller, datapath
// feature beat: one class per cycle, up to NUM_CLASSES (max 8), through the shared
// z-squared pipeline, then a drain; the next beat is accepted only when idle; a last
// feature then compares the classes in use and gives the result strobe, never stalled
// synchronous reset clears control, accumulators and sets classes_in_use to 8
// depends on gnb_pkg, gnb_controller, gnb_datapath, assert_macros.svh
`include "assert_macros.svh"

module gaussian_naive_bayes_classifier
   import gnb_pkg::*;
#(
   parameter int NUM_CLASSES  = 8,
   parameter int NUM_FEATURES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int         CLS_N         = (NUM_CLASSES < CLASS_CAP) ? NUM_CLASSES : CLASS_CAP;
   localparam logic       REG_CLS_INUSE = 1'b0;
   localparam logic [3:0] CLS_INUSE_RST = 4'd8;

   logic [3:0] classes_in_use_ff, classes_in_use_in;
   ctl_type    ctl;
   stat_type   stat;

   assign pready = 1'b1;

   always_comb begin
      classes_in_use_in = classes_in_use_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_CLS_INUSE)) begin
         classes_in_use_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         classes_in_use_ff <= CLS_INUSE_RST;
      end else begin
         classes_in_use_ff <= classes_in_use_in;
      end
   end

   assign prdata = (paddr[2] == REG_CLS_INUSE) ? {28'd0, classes_in_use_ff} : 32'd0;

   gnb_controller #(
      .NUM_CLASSES  (NUM_CLASSES),
      .NUM_FEATURES (NUM_FEATURES)
   ) u_controller (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_payload    (req_payload),
      .classes_in_use (classes_in_use_ff),
      .stat           (stat),
      .ctl            (ctl),
      .busy           (busy)
   );

   gnb_datapath #(
      .NUM_CLASSES  (NUM_CLASSES),
      .NUM_FEATURES (NUM_FEATURES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   assign rsp_valid = ctl.emit;

   `GNB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "beat did not raise busy")
   `GNB_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy, "double strobe")
   `GNB_ASSERT_NOW(a_class_range, clock, reset, rsp_valid,
      int'(rsp_payload.best_class) < CLS_N, "class out of range")
   `GNB_ASSERT_NOW(a_pipe_empty, clock, reset, rsp_valid, !stat.pipe_busy, "result with pipe busy")

endmodule

>>> dv/testbench.sv
// self-checking testbench for gaussian_naive_bayes_classifier: loads class models,
// streams samples and checks every decision against a scoring model kept in the bench
// depends on gnb_pkg and the classifier rtl
`timescale 1ns / 100ps

module testbench;
   import gnb_pkg::*;

   localparam int NUM_CLASSES  = 8;
   localparam int NUM_FEATURES = 64;
   localparam logic [2:0] ADDR_CLASSES_IN_USE = 3'd0;
   localparam longint ACC_HI = 64'sd549755813887;
   localparam longint ACC_LO = -64'sd549755813888;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gaussian_naive_bayes_classifier #(
      .NUM_CLASSES (NUM_CLASSES),
      .NUM_FEATURES(NUM_FEATURES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // scoring model state
   logic [31:0] model_bias [NUM_CLASSES];
   logic [15:0] model_mean [NUM_CLASSES*NUM_FEATURES];
   logic [15:0] model_inv  [NUM_CLASSES*NUM_FEATURES];
   longint      class_score [NUM_CLASSES];
   logic [3:0]  classes_cfg;
   rsp_type     expected_decisions [$];

   req_type     pending_commands [$];
   logic        beat_taken = 1'b0;
   bit          steady_run = 1'b0;
   int          mismatch_count = 0;
   int          commands_taken = 0;
   int          decisions_checked = 0;
   int          cfg_writes = 0;

   // stimulus-side view of which model entries exist
   logic [15:0] loaded_mask [NUM_FEATURES];
   int          ready_features [$];
   int          items_planned = 0;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50)
         $display("error at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
   endfunction

   function automatic longint half_z_sq(input longint x, input longint mu, input longint inv);
      longint z;
      z = ((x - mu) * inv) >>> 8;
      if (z > 32767) z = 32767;
      else if (z < -32768) z = -32768;
      return (z * z) / 2;
   endfunction

   task automatic score_command(input req_type r);
      int      a;
      int      n;
      int      best;
      longint  x;
      longint  b;
      longint  s;
      longint  best_s;
      rsp_type d;
      a = int'(r.class_sel) * NUM_FEATURES + int'(r.feature_sel);
      case (r.command)
         CMD_BIAS:    model_bias[r.class_sel] = r.value;
         CMD_MEAN:    model_mean[a] = r.value[15:0];
         CMD_INV_STD: model_inv[a] = r.value[15:0];
         CMD_FEATURE: begin
            x = $signed(r.value[15:0]);
            for (int c = 0; c < NUM_CLASSES; c++) begin
               a = c * NUM_FEATURES + int'(r.feature_sel);
               class_score[c] = clamp_acc(class_score[c]
                  - half_z_sq(x, $signed(model_mean[a]), model_inv[a]));
            end
            if (r.last_feature) begin
               n = classes_cfg;
               if (n < 1) n = 1;
               if (n > NUM_CLASSES) n = NUM_CLASSES;
               best = 0;
               best_s = ACC_LO;
               for (int c = 0; c < n; c++) begin
                  b = $signed(model_bias[c]);
                  s = clamp_acc(class_score[c] + b);
                  if (c == 0 || s > best_s) begin
                     best_s = s;
                     best = c;
                  end
               end
               d.best_class = best[2:0];
               d.best_score = best_s[39:0];
               expected_decisions.push_back(d);
               for (int c = 0; c < NUM_CLASSES; c++) class_score[c] = 0;
            end
         end
      endcase
   endtask

   // monitor: results, accepted beats and register writes
   always @(posedge clock) begin
      rsp_type want;
      beat_taken <= !reset && start && !busy;
      if (reset) begin
         classes_cfg <= 4'd8;
         for (int c = 0; c < NUM_CLASSES; c++) class_score[c] = 0;
      end else begin
         if (rsp_valid) begin
            decisions_checked++;
            if (expected_decisions.size() == 0) begin
               report_mismatch($sformatf("unexpected decision class %0d score %0d",
                  rsp_payload.best_class, rsp_payload.best_score));
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_payload.best_class !== want.best_class)
                  report_mismatch($sformatf("best_class %0d, want %0d",
                     rsp_payload.best_class, want.best_class));
               if (rsp_payload.best_score !== want.best_score)
                  report_mismatch($sformatf("best_score %0d, want %0d",
                     rsp_payload.best_score, want.best_score));
            end
         end
         if (start && !busy) begin
            commands_taken++;
            score_command(req_payload);
         end
         if (psel && penable && pwrite && pready && paddr == ADDR_CLASSES_IN_USE)
            classes_cfg <= pwdata[3:0];
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_commands.size() != 0 && (steady_run || $urandom_range(99) >= 36)) begin
            start       <= 1'b1;
            req_payload <= pending_commands.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic csr_access(input bit is_write, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= ADDR_CLASSES_IN_USE;
      pwdata  <= is_write ? data : '0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (!is_write && prdata !== data)
         report_mismatch($sformatf("classes_in_use reads %0h, want %0h", prdata, data));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_classes(input logic [3:0] n);
      csr_access(1'b1, 32'(n));
      csr_access(1'b0, 32'(n));
      cfg_writes++;
   endtask

   task automatic push_item(input logic [1:0] cmd, input int cls, input int feat,
                            input logic [31:0] val, input bit last);
      req_type r;
      int      bitpos;
      r.command      = cmd;
      r.class_sel    = cls[2:0];
      r.feature_sel  = feat[5:0];
      r.value        = val;
      r.last_feature = last;
      pending_commands.push_back(r);
      items_planned++;
      if ((cmd == CMD_MEAN || cmd == CMD_INV_STD) && loaded_mask[feat] != 16'hffff) begin
         bitpos = (cmd == CMD_INV_STD) ? 8 + cls : cls;
         loaded_mask[feat][bitpos] = 1'b1;
         if (loaded_mask[feat] == 16'hffff) ready_features.push_back(feat);
      end
   endtask

   function automatic logic [15:0] pick_q88();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4: return 16'($urandom_range(1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_inv();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h0100;
         3, 4: return 16'($urandom_range(1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_bias();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3, 4: return 32'($urandom_range(2097151)) - 32'd1048576;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_feature(input int feat);
      for (int c = 0; c < NUM_CLASSES; c++) begin
         push_item(CMD_MEAN, c, feat, {16'($urandom), pick_q88()}, $urandom_range(1));
         push_item(CMD_INV_STD, c, feat, {16'($urandom), pick_inv()}, $urandom_range(1));
      end
   endtask

   task automatic push_sample(input int n);
      int f;
      for (int k = 0; k < n; k++) begin
         f = ready_features[$urandom_range(ready_features.size() - 1)];
         push_item(CMD_FEATURE, $urandom_range(7), f, {16'($urandom), pick_q88()}, k == n - 1);
      end
   endtask

   task automatic wait_until_idle();
      while (pending_commands.size() != 0 || start || expected_decisions.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int stop_at;
      stop_at = items_planned + count;
      while (items_planned < stop_at) begin
         case ($urandom_range(9))
            0: push_item(CMD_BIAS, $urandom_range(7), $urandom_range(63), pick_bias(),
                         $urandom_range(1));
            1: push_item($urandom_range(1) ? CMD_MEAN : CMD_INV_STD, $urandom_range(7),
                         $urandom_range(63), {16'($urandom), $urandom_range(1) ?
                         pick_q88() : pick_inv()}, $urandom_range(1));
            2: if ($urandom_range(3) == 0) load_feature($urandom_range(63));
            3: push_item(CMD_FEATURE, $urandom_range(7),
                         ready_features[$urandom_range(ready_features.size() - 1)],
                         {16'($urandom), pick_q88()}, 1'b0);
            default: push_sample($urandom_range(1, 6));
         endcase
      end
   endtask

   initial begin
      logic [3:0] settings [$];
      for (int f = 0; f < NUM_FEATURES; f++) loaded_mask[f] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset value of the class count
      csr_access(1'b0, 32'd8);

      // model setup: equal biases, unit spread on features 0 and 63
      for (int c = 0; c < NUM_CLASSES; c++) push_item(CMD_BIAS, c, 0, 32'h0, 1'b0);
      for (int c = 0; c < NUM_CLASSES; c++) begin
         push_item(CMD_MEAN, c, 0, 32'h0, 1'b0);
         push_item(CMD_INV_STD, c, 0, 32'h0000_0100, 1'b0);
         push_item(CMD_MEAN, c, 63, 32'hffff_0000, 1'b1);
         push_item(CMD_INV_STD, c, 63, 32'hffff_0100, 1'b1);
      end
      // all scores equal, lowest class wins
      push_item(CMD_FEATURE, 0, 0, 32'h0, 1'b1);
      // largest bias, z at its positive maximum
      push_item(CMD_BIAS, 5, 0, 32'h7fff_ffff, 1'b1);
      push_item(CMD_FEATURE, 7, 63, 32'h0000_7fff, 1'b1);
      // z saturating negative on one class, most negative bias
      push_item(CMD_MEAN, 2, 0, 32'h0000_7fff, 1'b0);
      push_item(CMD_INV_STD, 2, 0, 32'h0000_ffff, 1'b0);
      push_item(CMD_BIAS, 7, 0, 32'h8000_0000, 1'b0);
      push_item(CMD_FEATURE, 0, 0, 32'h7fff_8000, 1'b1);
      // tiny negative product rounds toward minus infinity
      push_item(CMD_MEAN, 3, 63, 32'h0000_0001, 1'b0);
      push_item(CMD_INV_STD, 3, 63, 32'h0000_0001, 1'b0);
      push_item(CMD_FEATURE, 0, 63, 32'h0, 1'b0);
      push_item(CMD_FEATURE, 0, 0, 32'h0000_0100, 1'b0);
      push_item(CMD_FEATURE, 7, 63, 32'h1234_ff00, 1'b1);
      push_item(CMD_INV_STD, 6, 0, 32'h0000_0000, 1'b1);
      push_item(CMD_FEATURE, 0, 0, 32'h0000_0040, 1'b1);
      random_phase(30);
      wait_until_idle();

      settings = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd9, 4'($urandom_range(2, 7))};
      foreach (settings[i]) begin
         set_classes(settings[i]);
         steady_run = (i == 2);
         random_phase(45);
         wait_until_idle();
         if (i == 3) begin
            // long sample of largest terms, back to back
            steady_run = 1'b1;
            push_item(CMD_BIAS, 0, 0, 32'h8000_0000, 1'b0);
            for (int c = 0; c < NUM_CLASSES; c++) begin
               push_item(CMD_MEAN, c, 10, 32'h0000_7fff, 1'b0);
               push_item(CMD_INV_STD, c, 10, 32'h0000_ffff, 1'b0);
            end
            for (int k = 0; k < 24; k++)
               push_item(CMD_FEATURE, k % 8, 10, 32'h0000_8000, k == 23);
            wait_until_idle();
            steady_run = 1'b0;
         end
      end

      $display("%0d commands accepted, %0d decisions checked", commands_taken, decisions_checked);
      $display("%0d class count settings, including zero and over the limit", cfg_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/gnb_pkg.sv
hw/rtl/gnb_ram.sv
hw/rtl/gnb_controller.sv
hw/rtl/gnb_datapath.sv
hw/rtl/gaussian_naive_bayes_classifier.sv
dv/testbench.sv
